### design/sprite_rect_clip_uv_assert.svh
// Assertion macros for the sprite clipper; only src_back includes them.
// Included by files that check their own logic; no other dependencies.
`ifndef SPRITE_RECT_CLIP_UV_ASSERT_SVH
`define SPRITE_RECT_CLIP_UV_ASSERT_SVH
`ifndef SYNTH
`define SRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRC_ASSERT(label, clk, rst, prop, msg)
`define SRC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### design/src_pkg.sv
// Package for the sprite clipper: widths, register indexes, shared types.
// No dependencies.
package src_pkg;
  localparam int CoordW = 16;
  localparam int SizeW = 15;
  localparam int UvW = 16;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_RIGHT  = 2'd1,
    REG_CLIP_TOP    = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  localparam logic [CoordW-1:0] ClipLeftRst = 16'sd0;
  localparam logic [CoordW-1:0] ClipRightRst = 16'sd10240;
  localparam logic [CoordW-1:0] ClipTopRst = 16'sd0;
  localparam logic [CoordW-1:0] ClipBottomRst = 16'sd7680;

  typedef struct packed {
    logic signed [CoordW-1:0] left_x;
    logic signed [CoordW-1:0] top_y;
    logic [15:0] depth;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic [UvW-1:0] u_start;
    logic [UvW-1:0] v_start;
    logic [UvW-1:0] u_end;
    logic [UvW-1:0] v_end;
    logic [31:0] colour_in;
    logic [7:0] texture_in;
  } sprite_t;

  typedef struct packed {
    logic [1:0] corner;
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic [15:0] depth_out;
    logic [UvW-1:0] tex_u;
    logic [UvW-1:0] tex_v;
    logic [31:0] colour_out;
    logic [7:0] texture_out;
    logic last_corner;
  } vertex_t;

  typedef struct packed {
    logic [UvW-1:0] u1;
    logic [UvW-1:0] v1;
    logic [UvW-1:0] u2;
    logic [UvW-1:0] v2;
  } uvbox_t;

  // Finished sprite: clipped box plus pass-through fields.
  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    uvbox_t uv;
    logic [15:0] depth;
    logic [31:0] colour;
    logic [7:0] texture;
  } quad_t;

  // Classified request handed from the front to the back through the queue.
  typedef struct packed {
    logic signed [CoordW+1:0] x1;
    logic signed [CoordW+1:0] x2;
    logic signed [CoordW+1:0] y1;
    logic signed [CoordW+1:0] y2;
    logic signed [CoordW+1:0] cl;
    logic signed [CoordW+1:0] cr;
    logic signed [CoordW+1:0] ct;
    logic signed [CoordW+1:0] cb;
    uvbox_t uv;
    logic [15:0] depth;
    logic [31:0] colour;
    logic [7:0] texture;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LMUL, ST_LDIV, ST_RMUL, ST_RDIV,
    ST_TMUL, ST_TDIV, ST_BMUL, ST_BDIV, ST_DONE
  } bstate_t;
endpackage

### design/src_if.sv
// Valid/ready channel carrying one payload of a chosen type.
// Uses src_pkg types at the instantiation site.
interface src_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/src_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on src_pkg for widths.
interface src_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [src_pkg::CoordW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/src_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on src_pkg for widths.
module src_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [src_pkg::UvW+src_pkg::CoordW+1:0] dividend,
  input  logic [src_pkg::CoordW+1:0] divisor,
  output logic busy,
  output logic [src_pkg::UvW+src_pkg::CoordW+1:0] quotient
);
  import src_pkg::*;
  localparam int NW = UvW + CoordW + 2;
  localparam int DW = CoordW + 2;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0] trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign busy = (cnt != '0);
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

### design/src_front.sv
// Front end: holds clip registers, accepts sprites, rejects those outside.
// Depends on src_pkg, src_stream_if and src_cfg_if.
module src_front (
  input  logic clk,
  input  logic rst,
  src_cfg_if.sink cfg,
  src_stream_if.sink sprite_in,
  output logic job_valid,
  input  logic job_ready,
  output src_pkg::job_t job
);
  import src_pkg::*;

  logic signed [CoordW-1:0] clip_left, clip_right, clip_top, clip_bottom;
  job_t j;
  logic keep;
  logic signed [CoordW+1:0] xl, yl;

  assign cfg.ready = 1'b1;
  assign sprite_in.ready = job_ready;
  assign job_valid = sprite_in.valid && keep;
  assign job = j;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left <= ClipLeftRst;
      clip_right <= ClipRightRst;
      clip_top <= ClipTopRst;
      clip_bottom <= ClipBottomRst;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_CLIP_LEFT: clip_left <= cfg.data;
        REG_CLIP_RIGHT: clip_right <= cfg.data;
        REG_CLIP_TOP: clip_top <= cfg.data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    j.x1 = (CoordW+2)'(sprite_in.data.left_x);
    j.y1 = (CoordW+2)'(sprite_in.data.top_y);
    j.x2 = j.x1 + $signed({3'b0, sprite_in.data.width});
    j.y2 = j.y1 + $signed({3'b0, sprite_in.data.height});
    j.cl = (CoordW+2)'(clip_left);
    j.cr = (CoordW+2)'(clip_right);
    j.ct = (CoordW+2)'(clip_top);
    j.cb = (CoordW+2)'(clip_bottom);
    j.uv.u1 = sprite_in.data.u_start;
    j.uv.v1 = sprite_in.data.v_start;
    j.uv.u2 = sprite_in.data.u_end;
    j.uv.v2 = sprite_in.data.v_end;
    j.depth = sprite_in.data.depth;
    j.colour = sprite_in.data.colour_in;
    j.texture = sprite_in.data.texture_in;
    xl = (j.x1 < j.cl) ? j.cl : j.x1;
    yl = (j.y1 < j.ct) ? j.ct : j.y1;
    keep = !(j.x2 < j.cl) && !(xl > j.cr) && !(j.y2 < j.ct) && !(yl > j.cb);
  end
endmodule

### design/src_queue.sv
// Small FIFO of classified requests between the front and the back.
// Depends on src_pkg.
module src_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  src_pkg::job_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output src_pkg::job_t out_data
);
  import src_pkg::*;
  localparam int AW = $clog2(QDepth);

  job_t mem [QDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != (AW+1)'(QDepth));
  assign out_valid = (cnt != '0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end
endmodule

### design/src_back.sv
// Back end: clips each edge in turn with a shared multiplier and divider,
// then emits four corner vertices. Depends on src_pkg, src_divider, macros.
`include "sprite_rect_clip_uv_assert.svh"
module src_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  src_pkg::job_t job_in,
  src_stream_if.source vtx_out
);
  import src_pkg::*;
  localparam int SW = CoordW + 2;
  localparam int NW = UvW + CoordW + 2;

  bstate_t state, state_next;
  job_t w;
  logic signed [SW-1:0] xs, ys;
  logic signed [UvW:0] dt;
  logic [SW-1:0] ov;
  logic [NW-1:0] prod;
  logic neg;
  logic div_start, div_busy;
  logic [NW-1:0] quo;
  logic signed [NW:0] sq;
  quad_t quad;
  logic quad_valid;
  logic [1:0] k;
  logic take;
  logic clip_hit;
  logic started;

  src_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(((state == ST_LDIV) || (state == ST_RDIV)) ? xs : ys),
    .busy(div_busy), .quotient(quo)
  );

  assign take = job_valid && job_ready;
  assign job_ready = (state == ST_IDLE);
  assign sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // Whether the edge of the current multiply state needs clipping.
  always_comb begin
    case (state)
      ST_LMUL: clip_hit = w.x1 < w.cl;
      ST_RMUL: clip_hit = w.x2 > w.cr;
      ST_TMUL: clip_hit = w.y1 < w.ct;
      ST_BMUL: clip_hit = w.y2 > w.cb;
      default: clip_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = ST_LMUL;
      ST_LMUL: state_next = clip_hit ? ST_LDIV : ST_RMUL;
      ST_LDIV: if (!div_busy && !div_start) state_next = ST_RMUL;
      ST_RMUL: state_next = clip_hit ? ST_RDIV : ST_TMUL;
      ST_RDIV: if (!div_busy && !div_start) state_next = ST_TMUL;
      ST_TMUL: state_next = clip_hit ? ST_TDIV : ST_BMUL;
      ST_TDIV: if (!div_busy && !div_start) state_next = ST_BMUL;
      ST_BMUL: state_next = clip_hit ? ST_BDIV : ST_DONE;
      ST_BDIV: if (!div_busy && !div_start) state_next = ST_DONE;
      ST_DONE: if (!quad_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_LDIV, ST_RDIV, ST_TDIV, ST_BDIV: div_start = started;
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Multiply step registers the magnitude of delta times overhang;
  // the divider is started from the divide state in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) started <= 1'b0;
    else started <= (state_next == ST_LDIV || state_next == ST_RDIV ||
                     state_next == ST_TDIV || state_next == ST_BDIV) &&
                    (state == ST_LMUL || state == ST_RMUL ||
                     state == ST_TMUL || state == ST_BMUL);
  end

  logic [NW-1:0] mag;
  logic signed [NW+1:0] full;
  always_comb begin
    case (state)
      ST_LMUL, ST_RMUL: dt = $signed({1'b0, w.uv.u2}) - $signed({1'b0, w.uv.u1});
      default: dt = $signed({1'b0, w.uv.v2}) - $signed({1'b0, w.uv.v1});
    endcase
    case (state)
      ST_LMUL: ov = w.cl - w.x1;
      ST_RMUL: ov = w.x2 - w.cr;
      ST_TMUL: ov = w.ct - w.y1;
      default: ov = w.y2 - w.cb;
    endcase
    full = dt * $signed({1'b0, ov});
    mag = full[NW+1] ? NW'(-full) : NW'(full);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      w <= job_in;
      xs <= job_in.x2 - job_in.x1;
      ys <= job_in.y2 - job_in.y1;
    end else begin
      case (state)
        ST_LMUL, ST_RMUL, ST_TMUL, ST_BMUL: if (clip_hit) begin
          prod <= mag;
          neg <= full[NW+1];
        end
        default: ;
      endcase
      case (state)
        ST_LDIV: if (!div_busy && !started) begin
          w.uv.u1 <= UvW'(w.uv.u1 + sq[UvW-1:0]);
          xs <= xs - (w.cl - w.x1);
          w.x1 <= w.cl;
        end
        ST_RDIV: if (!div_busy && !started) begin
          w.uv.u2 <= UvW'(w.uv.u2 - sq[UvW-1:0]);
          xs <= xs - (w.x2 - w.cr);
          w.x2 <= w.cr;
        end
        ST_TDIV: if (!div_busy && !started) begin
          w.uv.v1 <= UvW'(w.uv.v1 + sq[UvW-1:0]);
          ys <= ys - (w.ct - w.y1);
          w.y1 <= w.ct;
        end
        ST_BDIV: if (!div_busy && !started) begin
          w.uv.v2 <= UvW'(w.uv.v2 - sq[UvW-1:0]);
          ys <= ys - (w.y2 - w.cb);
          w.y2 <= w.cb;
        end
        default: ;
      endcase
    end
  end

  // Output stage: holds one finished quad and walks its four corners.
  logic leaving;
  assign leaving = vtx_out.valid && vtx_out.ready && (k == 2'd3);
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
      k <= '0;
    end else begin
      if (vtx_out.valid && vtx_out.ready) k <= k + 1'b1;
      if (leaving) quad_valid <= 1'b0;
      if (state == ST_DONE && !quad_valid) quad_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && !quad_valid) begin
      quad.x1 <= CoordW'(w.x1);
      quad.x2 <= CoordW'(w.x2);
      quad.y1 <= CoordW'(w.y1);
      quad.y2 <= CoordW'(w.y2);
      quad.uv <= w.uv;
      quad.depth <= w.depth;
      quad.colour <= w.colour;
      quad.texture <= w.texture;
    end
  end

  always_comb begin
    vtx_out.valid = quad_valid;
    vtx_out.data.corner = k;
    vtx_out.data.screen_x = (k == 2'd1 || k == 2'd2) ? quad.x2 : quad.x1;
    vtx_out.data.screen_y = (k[1]) ? quad.y2 : quad.y1;
    vtx_out.data.tex_u = (k == 2'd1 || k == 2'd2) ? quad.uv.u2 : quad.uv.u1;
    vtx_out.data.tex_v = (k[1]) ? quad.uv.v2 : quad.uv.v1;
    vtx_out.data.depth_out = quad.depth;
    vtx_out.data.colour_out = quad.colour;
    vtx_out.data.texture_out = quad.texture;
    vtx_out.data.last_corner = (k == 2'd3);
  end

  `SRC_ASSERT(a_corner_idle, clk, rst, !quad_valid |-> k == 2'd0, "corner count not reset")
  `SRC_ASSERT(a_take_idle, clk, rst, take |=> state == ST_LMUL, "request not started")
  `SRC_ASSERT(a_last_drop, clk, rst, leaving |=> !quad_valid || $past(state == ST_DONE), "quad lingers")
endmodule

### design/sprite_rect_clip_uv.sv
// Sprite rectangle clipper with texture coordinate correction.
// Each accepted sprite request is clipped edge by edge with one shared
// multiplier and a bit-serial divider; an edge that does not clip skips
// the divide. Four vertices then leave one per cycle, unless the output
// stalls, from a register stage while the next request is already being
// clipped. Sprites wholly outside the clip rectangle are dropped at the
// input and produce no vertices.
module sprite_rect_clip_uv (
  input  logic clk,
  input  logic rst,
  src_cfg_if.sink cfg,
  src_stream_if.sink sprite_in,
  src_stream_if.source vertex_out
);
  import src_pkg::*;

  logic job_valid, job_ready, q_valid, q_ready;
  job_t job, q_job;

  src_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .sprite_in(sprite_in),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  src_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(job_valid), .in_ready(job_ready),
    .in_data(job), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_job)
  );

  src_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job_ready(q_ready),
    .job_in(q_job), .vtx_out(vertex_out)
  );
endmodule

### tb/sprite_rect_clip_uv_checker.sv
// Checker for the sprite clipper: watches the configuration, sprite and vertex
// channels, predicts the clipped vertices and compares them in order.
// Depends on src_pkg for the sprite and vertex types and the register indexes.
module sprite_rect_clip_uv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_fire,
  input  logic [1:0]  cfg_index,
  input  logic [src_pkg::CoordW-1:0] cfg_data,
  input  logic        sprite_fire,
  input  src_pkg::sprite_t sprite,
  input  logic        vertex_fire,
  input  src_pkg::vertex_t vertex,
  output int          errors,
  output int          pending,
  output int          vertices_seen,
  output int          sprites_dropped
);
  import src_pkg::*;

  logic signed [CoordW-1:0] clip_l, clip_r, clip_t, clip_b;
  vertex_t vertex_q[$];

  assign pending = vertex_q.size();

  function automatic bit clip_span(inout longint lo, inout longint hi, inout longint span,
                                   inout longint t1, inout longint t2,
                                   input longint c0, input longint c1);
    if (lo < c0) begin
      if (hi < c0) return 0;
      t1 += ((t2 - t1) * (c0 - lo)) / span;
      span += lo - c0;
      lo = c0;
    end
    if (hi > c1) begin
      if (lo > c1) return 0;
      t2 += ((t2 - t1) * (c1 - hi)) / span;
      span -= hi - c1;
      hi = c1;
    end
    return 1;
  endfunction

  function automatic void predict_vertices(sprite_t s);
    longint x1, x2, y1, y2, w, h, u1, u2, v1, v2;
    longint cx[4], cy[4], cu[4], cv[4];
    vertex_t v;
    x1 = s.left_x;
    y1 = s.top_y;
    w = s.width;
    h = s.height;
    x2 = x1 + w;
    y2 = y1 + h;
    u1 = s.u_start;
    u2 = s.u_end;
    v1 = s.v_start;
    v2 = s.v_end;
    if (!clip_span(x1, x2, w, u1, u2, clip_l, clip_r) ||
        !clip_span(y1, y2, h, v1, v2, clip_t, clip_b)) begin
      sprites_dropped++;
      return;
    end
    cx = '{x1, x2, x2, x1};
    cy = '{y1, y1, y2, y2};
    cu = '{u1, u2, u2, u1};
    cv = '{v1, v1, v2, v2};
    for (int k = 0; k < 4; k++) begin
      v.corner = k[1:0];
      v.screen_x = cx[k][CoordW-1:0];
      v.screen_y = cy[k][CoordW-1:0];
      v.depth_out = s.depth;
      v.tex_u = cu[k][UvW-1:0];
      v.tex_v = cv[k][UvW-1:0];
      v.colour_out = s.colour_in;
      v.texture_out = s.texture_in;
      v.last_corner = (k == 3);
      vertex_q.push_back(v);
    end
  endfunction

  function automatic void compare_vertex(vertex_t got);
    vertex_t want;
    bit bad;
    if (vertex_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("vertex with no request pending: %p", got);
      return;
    end
    want = vertex_q.pop_front();
    bad = (got.corner !== want.corner) || (got.screen_x !== want.screen_x) ||
          (got.screen_y !== want.screen_y) || (got.depth_out !== want.depth_out) ||
          (got.tex_u !== want.tex_u) || (got.tex_v !== want.tex_v) ||
          (got.colour_out !== want.colour_out) || (got.texture_out !== want.texture_out) ||
          (got.last_corner !== want.last_corner);
    if (bad) begin
      errors++;
      if (errors <= 10) $display("vertex mismatch: expected %p got %p", want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clip_l <= ClipLeftRst;
      clip_r <= ClipRightRst;
      clip_t <= ClipTopRst;
      clip_b <= ClipBottomRst;
      vertex_q.delete();
      errors <= 0;
      vertices_seen <= 0;
      sprites_dropped <= 0;
    end else begin
      if (vertex_fire) begin
        compare_vertex(vertex);
        vertices_seen <= vertices_seen + 1;
      end
      if (sprite_fire) predict_vertices(sprite);
      if (cfg_fire) begin
        case (reg_idx_t'(cfg_index))
          REG_CLIP_LEFT: clip_l <= cfg_data;
          REG_CLIP_RIGHT: clip_r <= cfg_data;
          REG_CLIP_TOP: clip_t <= cfg_data;
          REG_CLIP_BOTTOM: clip_b <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/sprite_rect_clip_uv_tb.sv
// Top of the sprite clipper testbench: clock, reset, configuration phases,
// directed and random sprite requests, output stalls and the verdict.
// Depends on src_pkg, both channel interfaces and sprite_rect_clip_uv_checker.
module sprite_rect_clip_uv_tb;
  import src_pkg::*;

  localparam int LimitCycles = 1000000;
  localparam int DrainCycles = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors, pending, vertices_seen, sprites_dropped;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cnt = 0;
  bit hold_go = 0;
  int cycles = 0;
  int sent = 0;
  int clip_l = 0, clip_r = 10240, clip_t = 0, clip_b = 7680;

  src_cfg_if cfg_ch (clk);
  src_stream_if #(.payload_t(sprite_t)) sprite_ch (clk);
  src_stream_if #(.payload_t(vertex_t)) vertex_ch (clk);

  sprite_rect_clip_uv dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .sprite_in(sprite_ch),
    .vertex_out(vertex_ch)
  );

  sprite_rect_clip_uv_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_fire(cfg_ch.valid && cfg_ch.ready),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .sprite_fire(sprite_ch.valid && sprite_ch.ready),
    .sprite(sprite_ch.data),
    .vertex_fire(vertex_ch.valid && vertex_ch.ready),
    .vertex(vertex_ch.data),
    .errors(errors),
    .pending(pending),
    .vertices_seen(vertices_seen),
    .sprites_dropped(sprites_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("sprite_rect_clip_uv_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      vertex_ch.ready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 0;
      hold_cnt <= 400;
      vertex_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      vertex_ch.ready <= 1'b0;
    end else begin
      vertex_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[CoordW-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_clip(int l, int r, int t, int b);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_BOTTOM, b);
    cfg_ch.valid <= 1'b0;
    clip_l = l;
    clip_r = r;
    clip_t = t;
    clip_b = b;
  endtask

  task automatic send_sprite(sprite_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      sprite_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sprite_ch.valid <= 1'b1;
    sprite_ch.data <= s;
    do @(posedge clk); while (!sprite_ch.ready);
    sent++;
  endtask

  function automatic sprite_t make_sprite(int x, int y, int w, int h,
                                          int u1, int v1, int u2, int v2);
    sprite_t s;
    s.left_x = x[CoordW-1:0];
    s.top_y = y[CoordW-1:0];
    s.width = w[SizeW-1:0];
    s.height = h[SizeW-1:0];
    s.u_start = u1[UvW-1:0];
    s.v_start = v1[UvW-1:0];
    s.u_end = u2[UvW-1:0];
    s.v_end = v2[UvW-1:0];
    s.depth = 16'($urandom);
    s.colour_in = $urandom;
    s.texture_in = 8'($urandom);
    return s;
  endfunction

  function automatic int near_edge(int lo, int hi);
    int a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    return a - 1500 + $urandom_range(0, b - a + 3000);
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    if ($urandom_range(4) == 0) begin
      s = $bits(sprite_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      s = make_sprite(near_edge(clip_l, clip_r), near_edge(clip_t, clip_b),
                      $urandom_range(3) != 0 ? $urandom_range(0, 2000) : $urandom_range(0, 32767),
                      $urandom_range(3) != 0 ? $urandom_range(0, 2000) : $urandom_range(0, 32767),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
    return s;
  endfunction

  initial begin
    sprite_t s;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CLIP_LEFT;
    cfg_ch.data = '0;
    sprite_ch.valid = 1'b0;
    sprite_ch.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_sprite(make_sprite(100, 100, 200, 300, 0, 0, 65535, 65535));
    send_sprite(make_sprite(500, 500, 0, 0, 1000, 2000, 3000, 4000));
    send_sprite(make_sprite(-400, 200, 800, 100, 0, 100, 65535, 9000));
    send_sprite(make_sprite(10000, 200, 800, 100, 65535, 0, 0, 65535));
    send_sprite(make_sprite(-2000, -2000, 32767, 32767, 0, 0, 65535, 65535));
    send_sprite(make_sprite(-900, 100, 800, 100, 0, 0, 65535, 65535));
    send_sprite(make_sprite(-800, 100, 800, 100, 0, 0, 65535, 65535));
    send_sprite(make_sprite(10241, 100, 800, 100, 0, 0, 65535, 65535));
    send_sprite(make_sprite(10240, 100, 800, 100, 0, 0, 65535, 65535));
    send_sprite(make_sprite(100, -300, 50, 200, 500, 60000, 500, 100));
    send_sprite(make_sprite(100, 7600, 50, 200, 500, 100, 500, 60000));
    send_sprite(make_sprite(100, -600, 50, 500, 0, 0, 65535, 65535));
    send_sprite(make_sprite(100, 7681, 50, 500, 0, 0, 65535, 65535));
    send_sprite(make_sprite(-32768, -32768, 32767, 32767, 65535, 65535, 0, 0));
    send_sprite(make_sprite(32767, 32767, 32767, 32767, 0, 0, 65535, 65535));
    send_sprite({16'h7fff, 16'h8000, 16'hffff, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff,
                 16'hffff, 16'hffff, 32'hffffffff, 8'hff});
    send_sprite('0);
    sprite_ch.valid <= 1'b0;

    for (int p = 1; p <= 8; p++) begin
      case (p % 5)
        0: set_clip(0, 10240, 0, 7680);
        1: set_clip(-32768, 32767, -32768, 32767);
        2: set_clip(100, -100, 300, -300);
        3: set_clip(50, 50, 32767, 32767);
        default: set_clip($urandom_range(0, 4000) - 2000, $urandom_range(0, 8000),
                          $urandom_range(0, 4000) - 2000, $urandom_range(0, 8000));
      endcase
      case (p % 4)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 54; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      for (int i = 0; i < 44; i++) begin
        if (p == 4 && i == 5) hold_go = 1;
        if (p == 6 && i == 20) begin
          sprite_ch.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
        end
        s = random_sprite();
        send_sprite(s);
      end
      sprite_ch.valid <= 1'b0;
    end

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d sprites sent over eight clip settings, %0d vertices checked, %0d dropped.",
             sent, vertices_seen, sprites_dropped);
    if (errors == 0 && pending == 0) begin
      $display("sprite_rect_clip_uv_tb: done, clean");
    end else begin
      $display("sprite_rect_clip_uv_tb: done, errors");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/src_pkg.sv
design/src_if.sv
design/src_cfg_if.sv
design/src_divider.sv
design/src_front.sv
design/src_queue.sv
design/src_back.sv
design/sprite_rect_clip_uv.sv
tb/sprite_rect_clip_uv_checker.sv
tb/sprite_rect_clip_uv_tb.sv
